>>> rtl/core/reader_writer_lock_home_arbiter_defines.svh
// ----------------------------------------------------------------------------
// Reader/writer lock home arbiter assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef READER_WRITER_LOCK_HOME_ARBITER_DEFINES_SVH
`define READER_WRITER_LOCK_HOME_ARBITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RWLHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwlha assertion failed");

// Next-cycle implication, checked outside reset.
`define RWLHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwlha assertion failed");

`endif

>>> rtl/core/rwlha_pkg.sv
// ----------------------------------------------------------------------------
// Reader/writer lock home arbiter package
// Types, codes, constants and the lock transition function.
// ----------------------------------------------------------------------------
`default_nettype none

package rwlha_pkg;

    localparam int RANK_W        = 5;
    localparam int CNT_W         = 6;
    localparam int TAG_W         = 32;
    localparam int KIND_W        = 3;
    localparam int MAX_RANKS     = 32;
    localparam int NUM_RANKS_DEF = 32;
    localparam int WQ_DEPTH_DEF  = 16;
    localparam int RS_DEPTH_DEF  = 16;
    localparam int MAX_RESULTS   = 48;
    localparam int RES_CNT_W     = 6;
    localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_DESTROY = 2'd2,
        OP_INVALID = 2'd3
    } op_e;

    typedef enum logic [KIND_W-1:0] {
        KIND_WGRANT = 3'd0,
        KIND_RGRANT = 3'd1,
        KIND_ACK    = 3'd2,
        KIND_NOTICE = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_e;

    typedef enum logic [1:0] {
        GRANT_NONE,
        GRANT_WRITER,
        GRANT_READERS
    } grant_e;

    typedef enum logic [1:0] {
        TR_WACQ,
        TR_RACQ,
        TR_WREL,
        TR_RREL
    } tr_op_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WGRANT,
        ST_RDRAIN,
        ST_SCAN,
        ST_WQDRAIN,
        ST_FLUSH
    } state_e;

    typedef struct packed {
        logic [1:0]        operation;
        logic              mode;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  ack_tag;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [RANK_W-1:0] target_rank;
        logic [TAG_W-1:0]  tag_out;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              push_w;
        logic              push_r;
        logic              pop_w;
        logic              pop_r;
        logic              clr_head;
        logic              mark;
        logic [RANK_W-1:0] rank;
    } store_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0]     wq_count;
        logic [CNT_W-1:0]     rs_count;
        logic [RANK_W-1:0]    wq_rank;
        logic [RANK_W-1:0]    rs_rank;
        logic [MAX_RANKS-1:0] roster;
    } store_sts_t;

    typedef struct packed {
        logic [CNT_W-1:0] w;
        logic [CNT_W-1:0] r;
        logic             b;
        grant_e           g;
    } trans_t;

    function automatic trans_t transition(tr_op_e op, logic [CNT_W-1:0] w,
                                          logic [CNT_W-1:0] r, logic b);
        trans_t t;
        t.w = w;
        t.r = r;
        t.b = b;
        t.g = GRANT_NONE;
        unique case (op)
            TR_WACQ:
            begin
                if (w == '0 && r == '0)
                begin
                    t.g = GRANT_WRITER;
                end
                else if (w == '0)
                begin
                    t.b = 1'b1;
                end
                t.w = w + 1'b1;
            end
            TR_RACQ:
            begin
                if (w == '0)
                begin
                    t.g = GRANT_READERS;
                    t.b = 1'b1;
                end
                else if (b && r != '0)
                begin
                    t.g = GRANT_READERS;
                end
                else
                begin
                    t.b = 1'b0;
                end
                t.r = r + 1'b1;
            end
            TR_WREL:
            begin
                t.w = w - 1'b1;
                if (t.w != '0)
                begin
                    t.g = GRANT_WRITER;
                end
                else if (r != '0)
                begin
                    t.g = GRANT_READERS;
                    t.b = 1'b1;
                end
            end
            default:
            begin
                t.r = r - 1'b1;
                if (t.r == '0 && w != '0)
                begin
                    t.g = GRANT_WRITER;
                    t.b = 1'b0;
                end
            end
        endcase
        if (t.w == '0 || t.r == '0)
        begin
            t.b = 1'b0;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rwlha_store.sv
// ----------------------------------------------------------------------------
// Reader/writer lock home arbiter storage
// Writer rank FIFO, reader rank LIFO and the roster of requesting ranks.
// ----------------------------------------------------------------------------
`default_nettype none

module rwlha_store
    import rwlha_pkg::*;
#(
    parameter int NUM_RANKS = NUM_RANKS_DEF,
    parameter int WQ_DEPTH  = WQ_DEPTH_DEF,
    parameter int RS_DEPTH  = RS_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire store_ctl_t ctl,
    output store_sts_t      sts
);

    localparam int WQ_AW = $clog2(WQ_DEPTH);
    localparam int WQ_CW = $clog2(WQ_DEPTH + 1);
    localparam int RS_AW = $clog2(RS_DEPTH);
    localparam int RS_CW = $clog2(RS_DEPTH + 1);
    localparam int SW    = WQ_AW + 1;
    localparam int RIW   = $clog2(NUM_RANKS);

    logic [RANK_W-1:0]    wq_mem [WQ_DEPTH];
    logic [RANK_W-1:0]    rs_mem [RS_DEPTH];
    logic [WQ_AW-1:0]     wq_head_reg, wq_head_next;
    logic [WQ_CW-1:0]     wq_count_reg, wq_count_next;
    logic [RS_CW-1:0]     rs_count_reg, rs_count_next;
    logic [NUM_RANKS-1:0] roster_reg, roster_next;
    logic [SW-1:0]        tail_sum;
    logic [WQ_AW-1:0]     wq_tail;
    logic [RS_AW-1:0]     rs_top;

    always_comb
    begin
        tail_sum = SW'(wq_head_reg) + SW'(wq_count_reg);
        if (tail_sum >= SW'(WQ_DEPTH))
        begin
            tail_sum = tail_sum - SW'(WQ_DEPTH);
        end
        wq_tail = tail_sum[WQ_AW-1:0];
        rs_top  = RS_AW'(rs_count_reg - 1'b1);

        wq_head_next  = wq_head_reg;
        wq_count_next = wq_count_reg;
        rs_count_next = rs_count_reg;
        roster_next   = roster_reg;
        if (ctl.push_w)
        begin
            wq_count_next = wq_count_reg + 1'b1;
        end
        if (ctl.pop_w)
        begin
            wq_count_next = wq_count_reg - 1'b1;
            if (wq_head_reg == WQ_AW'(WQ_DEPTH - 1))
            begin
                wq_head_next = '0;
            end
            else
            begin
                wq_head_next = wq_head_reg + 1'b1;
            end
        end
        if (ctl.clr_head)
        begin
            wq_head_next = '0;
        end
        if (ctl.push_r)
        begin
            rs_count_next = rs_count_reg + 1'b1;
        end
        if (ctl.pop_r)
        begin
            rs_count_next = rs_count_reg - 1'b1;
        end
        if (ctl.mark)
        begin
            roster_next[ctl.rank[RIW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wq_head_reg  <= '0;
            wq_count_reg <= '0;
            rs_count_reg <= '0;
            roster_reg   <= '0;
        end
        else
        begin
            wq_head_reg  <= wq_head_next;
            wq_count_reg <= wq_count_next;
            rs_count_reg <= rs_count_next;
            roster_reg   <= roster_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push_w)
        begin
            wq_mem[wq_tail] <= ctl.rank;
        end
        if (ctl.push_r)
        begin
            rs_mem[rs_count_reg[RS_AW-1:0]] <= ctl.rank;
        end
    end

    assign sts.wq_count = CNT_W'(wq_count_reg);
    assign sts.rs_count = CNT_W'(rs_count_reg);
    assign sts.wq_rank  = wq_mem[wq_head_reg];
    assign sts.rs_rank  = rs_mem[rs_top];
    assign sts.roster   = MAX_RANKS'(roster_reg);

endmodule

`default_nettype wire

>>> rtl/core/rwlha_seq.sv
// ----------------------------------------------------------------------------
// Reader/writer lock home arbiter sequencer
// Lock counters, transition decision and the walk that emits result words.
// ----------------------------------------------------------------------------
`default_nettype none

module rwlha_seq
    import rwlha_pkg::*;
#(
    parameter int NUM_RANKS = NUM_RANKS_DEF,
    parameter int WQ_DEPTH  = WQ_DEPTH_DEF,
    parameter int RS_DEPTH  = RS_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire cmd_t              cmd,
    input  wire logic [RANK_W-1:0] self_rank,
    input  wire store_sts_t        sts,
    output store_ctl_t             ctl,
    output logic                   busy,
    output logic                   res_valid,
    output result_t                result
);

    localparam int RIW = $clog2(NUM_RANKS);

    state_e               state_reg, state_next;
    cmd_t                 item_reg, item_next;
    logic [CNT_W-1:0]     w_reg, w_next, r_reg, r_next;
    logic                 phase_reg, phase_next;
    logic [RIW-1:0]       scan_reg, scan_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              pend_reg, pend_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic                 cand_v;
    result_t              cand;
    logic                 err;
    trans_t               tr;
    state_e               grant_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            w_reg          <= CNT_W'(1);
            r_reg          <= '0;
            phase_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            scan_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            w_reg          <= w_next;
            r_reg          <= r_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            n_reg          <= n_next;
            scan_reg       <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        w_next          = w_reg;
        r_next          = r_reg;
        phase_next      = phase_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        n_next          = n_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        ctl             = '0;
        ctl.rank        = item_reg.rank;
        cand_v          = 1'b0;
        cand            = '0;
        err             = 1'b0;
        tr              = transition(TR_WACQ, w_reg, r_reg, phase_reg);
        grant_state     = ST_FLUSH;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !out_valid_reg)
                begin
                    item_next  = cmd;
                    n_next     = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                case (item_reg.operation)
                    OP_REQUEST:
                    begin
                        if ({1'b0, item_reg.rank} >= (RANK_W + 1)'(NUM_RANKS))
                        begin
                            err = 1'b1;
                        end
                        else if (item_reg.mode)
                        begin
                            err = (sts.wq_count >= CNT_W'(WQ_DEPTH)) || (w_reg >= COUNT_MAX);
                        end
                        else
                        begin
                            err = (sts.rs_count >= CNT_W'(RS_DEPTH)) || (r_reg >= COUNT_MAX);
                        end
                        if (!err)
                        begin
                            ctl.push_w = item_reg.mode;
                            ctl.push_r = !item_reg.mode;
                            ctl.mark   = 1'b1;
                            tr = transition(item_reg.mode ? TR_WACQ : TR_RACQ,
                                            w_reg, r_reg, phase_reg);
                        end
                    end
                    OP_RELEASE:
                    begin
                        err = ({1'b0, item_reg.rank} >= (RANK_W + 1)'(NUM_RANKS))
                            || (item_reg.mode ? (w_reg == '0) : (r_reg == '0));
                        if (!err)
                        begin
                            if (item_reg.mode && item_reg.ack_tag != '0)
                            begin
                                cand_v           = 1'b1;
                                cand.kind        = KIND_ACK;
                                cand.target_rank = item_reg.rank;
                                cand.tag_out     = item_reg.ack_tag;
                            end
                            tr = transition(item_reg.mode ? TR_WREL : TR_RREL,
                                            w_reg, r_reg, phase_reg);
                        end
                    end
                    OP_DESTROY:
                    begin
                        scan_next = '0;
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase
                unique case (tr.g)
                    GRANT_WRITER:  grant_state = ST_WGRANT;
                    GRANT_READERS: grant_state = ST_RDRAIN;
                    default:       grant_state = ST_FLUSH;
                endcase
                if (item_reg.operation == OP_DESTROY)
                begin
                    state_next = ST_SCAN;
                end
                else if (err)
                begin
                    cand_v           = 1'b1;
                    cand.kind        = KIND_ERROR;
                    cand.target_rank = item_reg.rank;
                    state_next       = ST_FLUSH;
                end
                else
                begin
                    w_next     = tr.w;
                    r_next     = tr.r;
                    phase_next = tr.b;
                    state_next = grant_state;
                end
            end
            ST_WGRANT:
            begin
                if (sts.wq_count != '0)
                begin
                    ctl.pop_w        = 1'b1;
                    cand_v           = 1'b1;
                    cand.kind        = KIND_WGRANT;
                    cand.target_rank = sts.wq_rank;
                end
                state_next = ST_FLUSH;
            end
            ST_RDRAIN:
            begin
                if (sts.rs_count != '0)
                begin
                    ctl.pop_r        = 1'b1;
                    cand_v           = 1'b1;
                    cand.kind        = KIND_RGRANT;
                    cand.target_rank = sts.rs_rank;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_SCAN:
            begin
                if (sts.roster[scan_reg] && RANK_W'(scan_reg) != self_rank)
                begin
                    cand_v           = 1'b1;
                    cand.kind        = KIND_NOTICE;
                    cand.target_rank = RANK_W'(scan_reg);
                end
                if (scan_reg == RIW'(NUM_RANKS - 1))
                begin
                    state_next = ST_WQDRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_WQDRAIN:
            begin
                if (sts.wq_count != '0)
                begin
                    ctl.pop_w = 1'b1;
                    if (sts.wq_rank != self_rank)
                    begin
                        cand_v           = 1'b1;
                        cand.kind        = KIND_NOTICE;
                        cand.target_rank = sts.wq_rank;
                    end
                end
                else
                begin
                    ctl.clr_head = 1'b1;
                    state_next   = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    out_next.last  = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cand_v && n_reg < RES_CNT_W'(MAX_RESULTS))
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.last  = 1'b0;
            end
            pend_next       = cand;
            pend_valid_next = 1'b1;
            n_next          = n_reg + 1'b1;
        end
    end

    assign busy      = (state_reg != ST_IDLE) || out_valid_reg;
    assign res_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/reader_writer_lock_home_arbiter.sv
// ----------------------------------------------------------------------------
// Reader/writer lock home arbiter
// Home-side grant logic for one shared object's reader/writer lock.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Each result
// word appears for one cycle with res_valid high and cannot be stalled; the
// final word of a command has last set. After a command is taken, busy stays
// high while the sequencer decides, grants a writer or drains the granted
// readers, or on destroy walks every roster rank and then the writer queue,
// and until the final word has been shown, all through the one sequencer.
`default_nettype none

module reader_writer_lock_home_arbiter
    import rwlha_pkg::*;
#(
    parameter int NUM_RANKS          = NUM_RANKS_DEF,
    parameter int WRITER_QUEUE_DEPTH = WQ_DEPTH_DEF,
    parameter int READER_STACK_DEPTH = RS_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire cmd_t        cmd,
    output logic             res_valid,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "reader_writer_lock_home_arbiter_defines.svh"

    logic [RANK_W-1:0] self_rank_reg;
    store_ctl_t        ctl;
    store_sts_t        sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(self_rank_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_rank_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            self_rank_reg <= pwdata[RANK_W-1:0];
        end
    end

    rwlha_store #(
        .NUM_RANKS (NUM_RANKS),
        .WQ_DEPTH  (WRITER_QUEUE_DEPTH),
        .RS_DEPTH  (READER_STACK_DEPTH)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts)
    );

    rwlha_seq #(
        .NUM_RANKS (NUM_RANKS),
        .WQ_DEPTH  (WRITER_QUEUE_DEPTH),
        .RS_DEPTH  (READER_STACK_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .self_rank (self_rank_reg),
        .sts       (sts),
        .ctl       (ctl),
        .busy      (busy),
        .res_valid (res_valid),
        .result    (result)
    );

    `RWLHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `RWLHA_ASSERT_NOW(a_result_busy, res_valid, busy)
    `RWLHA_ASSERT_NEXT(a_last_gap, res_valid && result.last, !res_valid)
    `RWLHA_ASSERT_NOW(a_error_last, res_valid && result.kind == KIND_ERROR, result.last)

endmodule

`default_nettype wire
